[rtl/box_filter_3x3_stream_core_assert.svh]
// Assertion macros shared by the box filter RTL.
// Each macro expects clk and rst_n in the enclosing module scope.
`ifndef BOX_FILTER_3X3_STREAM_CORE_ASSERT_SVH
`define BOX_FILTER_3X3_STREAM_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BF3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define BF3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bf3_pkg.sv]
// Shared types and constants of the 3x3 box filter.
// No dependencies; used by the interfaces and every RTL module.
package bf3_pkg;

  // Field widths
  localparam int PIX_W      = 8;
  localparam int OUT_W      = 12;
  localparam int SUM_W      = 12;
  localparam int CNT_W      = 4;
  localparam int FW_W       = 11;
  localparam int FH_W       = 12;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_MODE  = 2'd2;

  // Register reset values
  localparam logic [FW_W-1:0]   FW_RST   = 11'd640;
  localparam logic [FH_W-1:0]   FH_RST   = 12'd480;
  localparam logic [MODE_W-1:0] MODE_RST = 2'd0;

  // Border modes (code 3 behaves as replicate)
  localparam logic [MODE_W-1:0] MODE_REPLICATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEIGHBOR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COPY      = 2'd2;

  // Item operations
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Full 3x3 neighborhood count
  localparam logic [CNT_W-1:0] CNT_FULL = 4'd9;

  // Odd factor of the divisor
  localparam logic [1:0] DIV_BY1 = 2'd0;
  localparam logic [1:0] DIV_BY3 = 2'd1;
  localparam logic [1:0] DIV_BY9 = 2'd2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Per-item control decided by the front end
  typedef struct packed {
    logic wr_en;       // shift window and update line stores
    logic has_out;     // item yields a result
    logic up;          // row above result is in the image
    logic down;        // row below result is in the image
    logic left;        // column left of result is in the image
    logic right;       // column right of result is in the image
    logic row_last;
    logic frame_last;
  } bf3_flags_t;

endpackage

[rtl/bf3_if.sv]
// Valid/ready stream interfaces for the box filter input and result channels.
// Depends on bf3_pkg for field widths.
interface bf3_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [bf3_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output operation, output pixel, input ready);
  modport sink   (input valid, input operation, input pixel, output ready);
endinterface

interface bf3_out_if;
  logic                      valid;
  logic                      ready;
  logic [bf3_pkg::OUT_W-1:0] filtered;
  logic                      row_last;
  logic                      frame_last;

  modport source (output valid, output filtered, output row_last, output frame_last,
                  input ready);
  modport sink   (input valid, input filtered, input row_last, input frame_last,
                  output ready);
endinterface

[rtl/bf3_front.sv]
// Front end: accepts items, tracks the raster position and classifies each item.
// Depends on bf3_pkg, bf3_in_if and the assertion macro header.
module bf3_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       restart,
  input  logic [bf3_pkg::FW_W-1:0]   frame_width,
  input  logic [bf3_pkg::FH_W-1:0]   frame_height,
  bf3_in_if.sink                     in_ch,
  input  logic                       q_full,
  output logic                       push,
  output logic [$clog2(MAX_WIDTH)-1:0] push_addr,
  output logic [bf3_pkg::PIX_W-1:0]  push_pixel,
  output bf3_pkg::bf3_flags_t        push_flags
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int CW     = ADDR_W + 1;
  localparam int FH_W   = bf3_pkg::FH_W;
  localparam int VR_W   = FH_W + 1;

  logic [CW-1:0]     ew, ew_m1;
  logic [FH_W-1:0]   eh, eh_m1;
  logic [ADDR_W-1:0] col_r, col_nxt;
  logic [FH_W-1:0]   row_r, row_nxt;
  logic [CW-1:0]     drn_r, drn_nxt;
  logic [CW-1:0]     col_inc;
  logic              accept, draining, skip, tail, vc0, row_last;
  logic [ADDR_W-1:0] vc, co;
  logic [VR_W-1:0]   vr, ro_full;
  logic [FH_W-1:0]   ro;

  // Effective frame size
  always_comb begin
    if (frame_width == '0) begin
      ew = CW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      ew = CW'(MAX_WIDTH);
    end else begin
      ew = CW'(frame_width);
    end
    eh = (frame_height == '0) ? FH_W'(1) : frame_height;
  end
  assign ew_m1 = ew - CW'(1);
  assign eh_m1 = eh - FH_W'(1);

  // Handshake
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Classification
  assign draining = row_r >= eh;
  assign skip     = (in_ch.operation == bf3_pkg::OP_DRAIN) && !draining;
  assign tail     = draining && (drn_r >= ew);

  always_comb begin
    if (tail) begin
      vc = '0;
      vr = VR_W'(eh) + VR_W'(1);
    end else if (draining) begin
      vc = drn_r[ADDR_W-1:0];
      vr = VR_W'(eh);
    end else begin
      vc = col_r;
      vr = VR_W'(row_r);
    end
  end

  // Result position: last column two rows back, or previous column one row back
  assign vc0      = vc == '0;
  assign ro_full  = vc0 ? (vr - VR_W'(2)) : (vr - VR_W'(1));
  assign ro       = ro_full[FH_W-1:0];
  assign co       = vc0 ? ew_m1[ADDR_W-1:0] : (vc - ADDR_W'(1));
  assign row_last = {1'b0, co} == ew_m1;

  always_comb begin
    push_flags.wr_en      = !tail;
    push_flags.has_out    = vc0 ? (vr >= VR_W'(2)) : (vr != '0);
    push_flags.up         = ro != '0;
    push_flags.down       = ro != eh_m1;
    push_flags.left       = co != '0;
    push_flags.right      = !row_last;
    push_flags.row_last   = row_last;
    push_flags.frame_last = row_last && (ro == eh_m1);
  end

  assign push       = accept && !skip;
  assign push_addr  = vc;
  assign push_pixel = draining ? '0 : in_ch.pixel;

  // Position update
  assign col_inc = {1'b0, col_r} + CW'(1);
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    drn_nxt = drn_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
      drn_nxt = '0;
    end else if (push) begin
      if (tail) begin
        col_nxt = '0;
        row_nxt = '0;
        drn_nxt = '0;
      end else if (draining) begin
        drn_nxt = drn_r + CW'(1);
      end else if (col_inc >= ew) begin
        col_nxt = '0;
        row_nxt = row_r + FH_W'(1);
        drn_nxt = '0;
      end else begin
        col_nxt = col_inc[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      drn_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      drn_r <= drn_nxt;
    end
  end

`include "box_filter_3x3_stream_core_assert.svh"
  `BF3_ASSERT_IMP(a_col_in_row, 1'b1, {1'b0, col_r} < ew, "column past frame width")
  `BF3_ASSERT_IMP(a_row_in_frame, 1'b1, row_r <= eh, "row past frame height")
  `BF3_ASSERT_NXT(a_tail_restart, accept && tail && !restart, (row_r == '0) && (drn_r == '0), "frame end did not restart position")

endmodule

[rtl/bf3_queue.sv]
// Short FIFO that decouples the front end from the filter back end.
// Depends on bf3_pkg and the assertion macro header.
module bf3_queue #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head_data
);

  localparam int DEPTH = bf3_pkg::QUEUE_DEPTH;

  logic [W-1:0]                   mem_r [DEPTH];
  logic [bf3_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [bf3_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  assign full       = cnt_r == bf3_pkg::QCNT_W'(DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_data  = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + bf3_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - bf3_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + bf3_pkg::QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + bf3_pkg::QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

`include "box_filter_3x3_stream_core_assert.svh"
  `BF3_ASSERT_IMP(a_q_bound, 1'b1, cnt_r <= bf3_pkg::QCNT_W'(DEPTH), "queue count overflow")
  `BF3_ASSERT_IMP(a_q_no_underflow, pop, cnt_r != '0, "pop from empty queue")
  `BF3_ASSERT_IMP(a_q_no_overflow, push, !full, "push into full queue")

endmodule

[rtl/bf3_back.sv]
// Back end: line stores, 3x3 window, neighborhood sum and rounding divide.
// Depends on bf3_pkg, bf3_out_if and the assertion macro header.
module bf3_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int FRAC_BITS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [bf3_pkg::MODE_W-1:0]   border_mode,
  input  logic                         q_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_addr,
  input  logic [bf3_pkg::PIX_W-1:0]    q_pixel,
  input  bf3_pkg::bf3_flags_t          q_flags,
  output logic                         q_pop,
  bf3_out_if.source                    out_ch
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int PIX_W  = bf3_pkg::PIX_W;
  localparam int SUM_W  = bf3_pkg::SUM_W;
  localparam int CNT_W  = bf3_pkg::CNT_W;
  localparam int OUT_W  = bf3_pkg::OUT_W;
  localparam int Y_W    = SUM_W + FRAC_BITS;
  localparam int SH     = Y_W + 4;
  localparam int M_W    = SH + 1;
  localparam int P_W    = Y_W + M_W;

  // Reciprocals, exact for every dividend below 2^Y_W
  localparam logic [M_W-1:0] M_ONE   = M_W'(64'd1 << SH);
  localparam logic [M_W-1:0] M_THIRD = M_W'(((64'd1 << SH) + 64'd2) / 64'd3);
  localparam logic [M_W-1:0] M_NINTH = M_W'(((64'd1 << SH) + 64'd8) / 64'd9);

  // Column sum with edge rows replicated
  function automatic logic [SUM_W-1:0] col_rep(input logic [PIX_W-1:0] t,
                                               input logic [PIX_W-1:0] m,
                                               input logic [PIX_W-1:0] b,
                                               input logic up, input logic dn);
    logic [PIX_W-1:0] tt;
    logic [PIX_W-1:0] bb;
    tt = up ? t : m;
    bb = dn ? b : m;
    return SUM_W'(tt) + SUM_W'(m) + SUM_W'(bb);
  endfunction

  // Column sum of in-image rows only
  function automatic logic [SUM_W-1:0] col_nb(input logic [PIX_W-1:0] t,
                                              input logic [PIX_W-1:0] m,
                                              input logic [PIX_W-1:0] b,
                                              input logic up, input logic dn);
    logic [PIX_W-1:0] tt;
    logic [PIX_W-1:0] bb;
    tt = up ? t : '0;
    bb = dn ? b : '0;
    return SUM_W'(tt) + SUM_W'(m) + SUM_W'(bb);
  endfunction

  logic                adv, wr_go;
  logic [PIX_W-1:0]    above_mem [MAX_WIDTH];
  logic [PIX_W-1:0]    two_mem   [MAX_WIDTH];
  logic [PIX_W-1:0]    rd_mid_r, rd_top_r, fwd_mid_r, fwd_top_r, mid_eff, top_eff;
  logic                fwd_r;

  logic                a_vld_r;
  logic [ADDR_W-1:0]   a_addr_r;
  logic [PIX_W-1:0]    a_px_r;
  bf3_pkg::bf3_flags_t a_flags_r;

  logic [PIX_W-1:0]    win_l_r [3];
  logic [PIX_W-1:0]    win_c_r [3];

  logic [SUM_W-1:0]    rep_l, rep_c, rep_r, nb_l, nb_c, nb_r, sum_rep, sum_nb, a_sum;
  logic [1:0]          nr, nc;
  logic [CNT_W-1:0]    cnt_nb, a_cnt;
  logic                interior;

  logic                b_vld_r, b_rl_r, b_fl_r;
  logic [SUM_W-1:0]    b_sum_r;
  logic [CNT_W-1:0]    b_cnt_r;
  logic [1:0]          b_shift, b_div;
  logic [Y_W-1:0]      b_y, b_z;
  logic [M_W-1:0]      b_m;

  logic                c_vld_r, c_rl_r, c_fl_r;
  logic [Y_W-1:0]      c_z_r;
  logic [M_W-1:0]      c_m_r;

  logic                d_vld_r, d_rl_r, d_fl_r;
  logic [P_W-1:0]      d_p_r;

  logic                out_valid_r, out_rl_r, out_fl_r;
  logic [OUT_W-1:0]    out_filt_r;

  // Whole back pipeline moves when the output register can take a result
  assign adv   = !out_valid_r || out_ch.ready;
  assign q_pop = adv && q_valid;
  assign wr_go = adv && a_vld_r && a_flags_r.wr_en;

  // Line stores: read on pop, written when the item leaves the read stage
  always_ff @(posedge clk) begin
    if (adv) rd_mid_r <= above_mem[q_addr];
    if (wr_go) above_mem[a_addr_r] <= a_px_r;
  end

  always_ff @(posedge clk) begin
    if (adv) rd_top_r <= two_mem[q_addr];
    if (wr_go) two_mem[a_addr_r] <= mid_eff;
  end

  // Bypass for a read that lands on the address written in the same cycle
  assign mid_eff = fwd_r ? fwd_mid_r : rd_mid_r;
  assign top_eff = fwd_r ? fwd_top_r : rd_top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (adv) begin
      fwd_r <= q_valid && a_vld_r && a_flags_r.wr_en && (q_addr == a_addr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_mid_r <= a_px_r;
      fwd_top_r <= mid_eff;
    end
  end

  // Read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && q_valid) begin
      a_addr_r  <= q_addr;
      a_px_r    <= q_pixel;
      a_flags_r <= q_flags;
    end
  end

  // Window: left and center columns; the right column comes from the read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        win_l_r[i] <= '0;
        win_c_r[i] <= '0;
      end
    end else if (wr_go) begin
      for (int i = 0; i < 3; i++) begin
        win_l_r[i] <= win_c_r[i];
      end
      win_c_r[0] <= top_eff;
      win_c_r[1] <= mid_eff;
      win_c_r[2] <= a_px_r;
    end
  end

  // Neighborhood sum and count
  always_comb begin
    rep_l   = col_rep(win_l_r[0], win_l_r[1], win_l_r[2], a_flags_r.up, a_flags_r.down);
    rep_c   = col_rep(win_c_r[0], win_c_r[1], win_c_r[2], a_flags_r.up, a_flags_r.down);
    rep_r   = col_rep(top_eff, mid_eff, a_px_r, a_flags_r.up, a_flags_r.down);
    nb_l    = col_nb(win_l_r[0], win_l_r[1], win_l_r[2], a_flags_r.up, a_flags_r.down);
    nb_c    = col_nb(win_c_r[0], win_c_r[1], win_c_r[2], a_flags_r.up, a_flags_r.down);
    nb_r    = col_nb(top_eff, mid_eff, a_px_r, a_flags_r.up, a_flags_r.down);
    sum_rep = (a_flags_r.left ? rep_l : rep_c) + rep_c + (a_flags_r.right ? rep_r : rep_c);
    sum_nb  = (a_flags_r.left ? nb_l : '0) + nb_c + (a_flags_r.right ? nb_r : '0);
    nr      = 2'd1 + 2'(a_flags_r.up) + 2'(a_flags_r.down);
    nc      = 2'd1 + 2'(a_flags_r.left) + 2'(a_flags_r.right);
    cnt_nb  = CNT_W'(nr) * CNT_W'(nc);
    interior = a_flags_r.up && a_flags_r.down && a_flags_r.left && a_flags_r.right;
    case (border_mode)
      bf3_pkg::MODE_NEIGHBOR: begin
        a_sum = sum_nb;
        a_cnt = cnt_nb;
      end
      bf3_pkg::MODE_COPY: begin
        a_sum = interior ? sum_rep : SUM_W'(win_c_r[1]);
        a_cnt = interior ? bf3_pkg::CNT_FULL : CNT_W'(1);
      end
      default: begin
        a_sum = sum_rep;
        a_cnt = bf3_pkg::CNT_FULL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r && a_flags_r.has_out;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sum_r <= a_sum;
      b_cnt_r <= a_cnt;
      b_rl_r  <= a_flags_r.row_last;
      b_fl_r  <= a_flags_r.frame_last;
    end
  end

  // Rounding: q = (num + cnt/2) / cnt, cnt split into a shift and an odd factor
  always_comb begin
    case (b_cnt_r)
      4'd2: begin
        b_shift = 2'd1;
        b_div   = bf3_pkg::DIV_BY1;
      end
      4'd3: begin
        b_shift = 2'd0;
        b_div   = bf3_pkg::DIV_BY3;
      end
      4'd4: begin
        b_shift = 2'd2;
        b_div   = bf3_pkg::DIV_BY1;
      end
      4'd6: begin
        b_shift = 2'd1;
        b_div   = bf3_pkg::DIV_BY3;
      end
      4'd9: begin
        b_shift = 2'd0;
        b_div   = bf3_pkg::DIV_BY9;
      end
      default: begin
        b_shift = 2'd0;
        b_div   = bf3_pkg::DIV_BY1;
      end
    endcase
    b_y = (Y_W'(b_sum_r) << FRAC_BITS) + Y_W'(b_cnt_r >> 1);
    b_z = b_y >> b_shift;
    case (b_div)
      bf3_pkg::DIV_BY3: b_m = M_THIRD;
      bf3_pkg::DIV_BY9: b_m = M_NINTH;
      default:          b_m = M_ONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  // Reciprocal multiply
  always_ff @(posedge clk) begin
    if (adv) begin
      c_z_r  <= b_z;
      c_m_r  <= b_m;
      c_rl_r <= b_rl_r;
      c_fl_r <= b_fl_r;
      d_p_r  <= P_W'(c_z_r) * P_W'(c_m_r);
      d_rl_r <= c_rl_r;
      d_fl_r <= c_fl_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && d_vld_r) begin
      out_filt_r <= d_p_r[SH +: OUT_W];
      out_rl_r   <= d_rl_r;
      out_fl_r   <= d_fl_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.filtered   = out_filt_r;
  assign out_ch.row_last   = out_rl_r;
  assign out_ch.frame_last = out_fl_r;

`include "box_filter_3x3_stream_core_assert.svh"
  `BF3_ASSERT_NXT(a_bypass, adv && q_valid && a_vld_r && a_flags_r.wr_en && (q_addr == a_addr_r), fwd_r, "line store bypass missed")
  `BF3_ASSERT_IMP(a_cnt_legal, b_vld_r, (b_cnt_r == 4'd1) || (b_cnt_r == 4'd2) || (b_cnt_r == 4'd3) || (b_cnt_r == 4'd4) || (b_cnt_r == 4'd6) || (b_cnt_r == 4'd9), "illegal divisor")
  `BF3_ASSERT_NXT(a_win_hold, !adv, $stable(win_c_r[1]), "window moved while stalled")

endmodule

[rtl/box_filter_3x3_stream_core.sv]
// 3x3 box filter over a raster pixel stream. The sustained rate is one item per
// clock unless the output stalls: the front end classifies an item in the cycle
// it is accepted, and the back end reads both line stores, updates the window,
// sums the neighborhood and divides through a reciprocal multiply. From the queue
// an item passes the read stage, the sum, operand and product registers and the
// output register. The result for pixel n comes with the item after pixel
// n+width, so a frame is closed by width+1 drain items. Line stores are never
// cleared; unwritten entries feed only masked rows. Register writes restart the
// frame position. Depends on bf3_pkg, bf3_if, bf3_front, bf3_queue and bf3_back.
module box_filter_3x3_stream_core #(
  parameter int MAX_WIDTH = 1024,
  parameter int FRAC_BITS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [bf3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bf3_pkg::CFG_DATA_W-1:0]  cfg_data,
  bf3_in_if.sink                          in_ch,
  bf3_out_if.source                       out_ch
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int PIX_W  = bf3_pkg::PIX_W;
  localparam int FLG_W  = $bits(bf3_pkg::bf3_flags_t);
  localparam int ENT_W  = ADDR_W + PIX_W + FLG_W;

  logic [bf3_pkg::FW_W-1:0]   frame_width_r;
  logic [bf3_pkg::FH_W-1:0]   frame_height_r;
  logic [bf3_pkg::MODE_W-1:0] border_mode_r;
  logic                       restart;

  logic                       push, q_full, q_pop, q_valid;
  logic [ADDR_W-1:0]          push_addr, q_addr;
  logic [PIX_W-1:0]           push_pixel, q_pixel;
  bf3_pkg::bf3_flags_t        push_flags, q_flags;
  logic [ENT_W-1:0]           push_data, head_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bf3_pkg::FW_RST;
      frame_height_r <= bf3_pkg::FH_RST;
      border_mode_r  <= bf3_pkg::MODE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bf3_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[bf3_pkg::FW_W-1:0];
        bf3_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[bf3_pkg::FH_W-1:0];
        bf3_pkg::REG_BORDER_MODE:  border_mode_r  <= cfg_data[bf3_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_wr_en && ((cfg_index == bf3_pkg::REG_FRAME_WIDTH) ||
                                 (cfg_index == bf3_pkg::REG_FRAME_HEIGHT) ||
                                 (cfg_index == bf3_pkg::REG_BORDER_MODE));

  bf3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (restart),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .in_ch        (in_ch),
    .q_full       (q_full),
    .push         (push),
    .push_addr    (push_addr),
    .push_pixel   (push_pixel),
    .push_flags   (push_flags)
  );

  // Queue entry packing
  assign push_data = {push_addr, push_pixel, push_flags};
  assign {q_addr, q_pixel, q_flags} = head_data;

  bf3_queue #(
    .W (ENT_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (head_data)
  );

  bf3_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .border_mode (border_mode_r),
    .q_valid     (q_valid),
    .q_addr      (q_addr),
    .q_pixel     (q_pixel),
    .q_flags     (q_flags),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule
